// ----- rtl/bat_pkg.sv -----
// Shared types and constants for the breakpoint address table.
// Used by breakpoint_address_table_unit; depends on nothing else.
`default_nettype none
package bat_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int ADDR_W        = 32;
    localparam int CMD_W         = 2;
    localparam int ENT_W         = 4;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CHECK  = 2'd2
    } t_bat_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } t_bat_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
    } t_bat_in;

    typedef struct packed {
        logic             ok;
        logic [ENT_W-1:0] entries_used;
    } t_bat_out;

endpackage
`default_nettype wire

// ----- rtl/breakpoint_address_table_unit.sv -----
// Breakpoint address table: slot store, enable bits, fill count and scan sequencer.
// Depends on bat_pkg for types and constants.
`default_nettype none
// Each command is one beat taken when start is high and busy is low. One
// shared 32-bit comparator walks the slots in use, one slot per cycle. After
// acceptance a command goes through the scan, one step per slot in use, a
// step to close the scan, the result state and then idle; an add to a full
// table or an unknown command skips the scan and goes straight to the
// result state. A match ends the scan early. busy stays high from
// acceptance until the result has been shown.
// The result is on o_result for exactly one cycle with o_valid high; it
// cannot be held off, so the receiver must take it in that cycle.
module breakpoint_address_table_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bat_pkg::t_bat_in  i_cmd,
    output logic                   o_valid,
    output bat_pkg::t_bat_out      o_result
);
    import bat_pkg::*;

    logic [ADDR_W-1:0] r_tab_addr [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_tab_en;

    t_bat_state        r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_ok, n_ok;

    logic              set_en, clr_en, append;
    logic [IDX_W-1:0]  scan_idx;
    logic [IDX_W-1:0]  fill_idx;
    logic              hit;
    logic              in_range;

    assign scan_idx = r_idx[IDX_W-1:0];
    assign fill_idx = r_count[IDX_W-1:0];
    assign in_range = (r_idx < r_count);
    assign hit      = (r_tab_addr[scan_idx] == r_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_tab_en <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (set_en) begin
                r_tab_en[scan_idx] <= 1'b1;
            end
            if (clr_en) begin
                r_tab_en[scan_idx] <= 1'b0;
            end
            if (append) begin
                r_tab_en[fill_idx] <= 1'b1;
            end
        end
    end

    // Slot addresses and command payload carry no reset.
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_idx  <= n_idx;
        r_ok   <= n_ok;
        if (append) begin
            r_tab_addr[fill_idx] <= r_addr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_addr  = r_addr;
        n_idx   = r_idx;
        n_count = r_count;
        n_ok    = r_ok;
        set_en  = 1'b0;
        clr_en  = 1'b0;
        append  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd  = i_cmd.command;
                    n_addr = i_cmd.address;
                    n_idx  = '0;
                    n_ok   = 1'b0;
                    // Full table refuses an add outright; an unknown command is dropped.
                    if ((i_cmd.command == CMD_ADD && r_count >= CNT_W'(TABLE_ENTRIES))
                        || (i_cmd.command != CMD_ADD && i_cmd.command != CMD_REMOVE
                            && i_cmd.command != CMD_CHECK)) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                priority if (in_range && hit && r_cmd == CMD_ADD) begin
                    set_en  = 1'b1;
                    n_ok    = 1'b1;
                    n_state = ST_RESP;
                end else if (in_range && hit && r_cmd == CMD_REMOVE) begin
                    clr_en  = 1'b1;
                    n_ok    = 1'b1;
                    n_state = ST_RESP;
                end else if (in_range && hit && r_tab_en[scan_idx]) begin
                    n_ok    = 1'b1;
                    n_state = ST_RESP;
                end else if (in_range) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    // End of the slots in use: append on add, miss otherwise.
                    if (r_cmd == CMD_ADD) begin
                        append  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        n_ok    = 1'b1;
                    end
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy                  = (r_state != ST_IDLE);
    assign o_valid               = (r_state == ST_RESP);
    assign o_result.ok           = r_ok;
    assign o_result.entries_used = ENT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count))
            |-> (r_count == $past(r_count) + CNT_W'(1) && $past(r_cmd) == CMD_ADD
                 && $past(r_state) == ST_SCAN))
        else $error("fill count moved other than by an append");

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result shown for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

endmodule
`default_nettype wire
